// ===== rtl/imdu_pkg.sv =====
// Shared types and constants for the integer matrix determinant unit.
// No dependencies.
`timescale 1ns / 1ps

package imdu_pkg;

    localparam int DATA_W          = 32;
    localparam int CNT_W           = 4;
    localparam int CFG_W           = 3;
    localparam int ADDR_W          = 3;
    localparam int DEFAULT_MAX_DIM = 4;

    localparam logic CFG_IDX_ROW = 1'b0;
    localparam logic CFG_IDX_COL = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] dim;
        logic             no_value;
    } job_meta_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_ACC,
        B_COPY
    } back_state_t;

endpackage

// ===== rtl/imdu_front.sv =====
// Front end: config registers, entry loader and job builder.
// Depends on imdu_pkg.
`timescale 1ns / 1ps

module imdu_front #(
    parameter int MAX_DIM = imdu_pkg::DEFAULT_MAX_DIM,
    parameter int IDX_W   = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [imdu_pkg::ADDR_W-1:0]           paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [imdu_pkg::DATA_W-1:0]           in_data,
    output logic                                  push,
    output logic [MAX_DIM*MAX_DIM*imdu_pkg::DATA_W-1:0] push_mat,
    output imdu_pkg::job_meta_t                   push_meta,
    input  logic                                  q_full
);

    localparam int N2 = MAX_DIM * MAX_DIM;
    localparam int CW = imdu_pkg::CNT_W;

    logic [imdu_pkg::CFG_W-1:0]  row_cfg_reg, col_cfg_reg;
    logic [CW-1:0]               row_reg, col_reg;
    logic [imdu_pkg::DATA_W-1:0] ld_reg [N2];
    logic [CW-1:0]               rows, cols;
    logic                        cfg_wr, accept, last;
    logic [IDX_W-1:0]            wr_idx;

    function automatic logic [CW-1:0] clamp_dim(input logic [imdu_pkg::CFG_W-1:0] v);
        logic [CW-1:0] r;
        r = CW'(v);
        if (v == '0)
            r = CW'(1);
        else if (r > CW'(MAX_DIM))
            r = CW'(MAX_DIM);
        return r;
    endfunction

    assign cfg_wr   = psel && penable && pwrite;
    assign rows     = clamp_dim(row_cfg_reg);
    assign cols     = clamp_dim(col_cfg_reg);
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign last     = (row_reg == rows - CW'(1)) && (col_reg == cols - CW'(1));
    assign wr_idx   = IDX_W'(int'(row_reg) * MAX_DIM + int'(col_reg));
    assign push     = accept && last;

    assign push_meta.dim      = rows;
    assign push_meta.no_value = (rows != cols);

    always_comb
    begin
        for (int e = 0; e < N2; e++)
        begin
            push_mat[e*imdu_pkg::DATA_W +: imdu_pkg::DATA_W] =
                (IDX_W'(e) == wr_idx) ? in_data : ld_reg[e];
        end
    end

    always_comb
    begin
        case (paddr[2])
            imdu_pkg::CFG_IDX_ROW: prdata = 32'(row_cfg_reg);
            imdu_pkg::CFG_IDX_COL: prdata = 32'(col_cfg_reg);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cfg_reg <= imdu_pkg::CFG_W'(4);
            col_cfg_reg <= imdu_pkg::CFG_W'(4);
            row_reg     <= '0;
            col_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == imdu_pkg::CFG_IDX_ROW)
                row_cfg_reg <= pwdata[imdu_pkg::CFG_W-1:0];
            else
                col_cfg_reg <= pwdata[imdu_pkg::CFG_W-1:0];
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            if (col_reg == cols - CW'(1))
            begin
                col_reg <= '0;
                row_reg <= last ? '0 : row_reg + CW'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            ld_reg[wr_idx] <= in_data;
    end

endmodule

// ===== rtl/imdu_queue.sv =====
// Two-entry job queue between loader and determinant engine.
// No dependencies; the file sets the house timescale itself.
`timescale 1ns / 1ps

module imdu_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/imdu_back.sv =====
// Determinant engine: division-free iteration X <- mu(X)*A, one shared MAC.
// Depends on imdu_pkg.
`timescale 1ns / 1ps

module imdu_back #(
    parameter int MAX_DIM = imdu_pkg::DEFAULT_MAX_DIM,
    parameter int IDX_W   = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        job_valid,
    input  logic [MAX_DIM*MAX_DIM*imdu_pkg::DATA_W-1:0] job_mat,
    input  imdu_pkg::job_meta_t                         job_meta,
    output logic                                        job_pop,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [imdu_pkg::DATA_W-1:0]                 out_det,
    output logic                                        out_no_value
);

    localparam int N2 = MAX_DIM * MAX_DIM;
    localparam int CW = imdu_pkg::CNT_W;
    localparam int DW = imdu_pkg::DATA_W;

    imdu_pkg::back_state_t state_reg, state_next;

    logic [DW-1:0] a_reg [N2];
    logic [DW-1:0] x_reg [N2];
    logic [DW-1:0] y_reg [N2];
    logic [CW-1:0] n_reg, step_reg, i_reg, j_reg, k_reg;
    logic [DW-1:0] acc_reg, tr_reg, p_reg;
    logic          out_valid_reg, out_nov_reg;
    logic [DW-1:0] out_det_reg;

    logic [DW-1:0] opnd, a_el, sum;
    logic          start, row_end, col_end;

    function automatic logic [IDX_W-1:0] idx(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return IDX_W'(int'(r) * MAX_DIM + int'(c));
    endfunction

    assign start   = (state_reg == imdu_pkg::B_IDLE) && job_valid && !out_valid_reg;
    assign job_pop = start;
    assign opnd    = (k_reg == i_reg) ? (DW'(0) - tr_reg) : x_reg[idx(i_reg, k_reg)];
    assign a_el    = a_reg[idx(k_reg, j_reg)];
    assign sum     = acc_reg + p_reg;
    assign col_end = (k_reg == n_reg - CW'(1));
    assign row_end = (j_reg == n_reg - CW'(1));

    assign out_valid    = out_valid_reg;
    assign out_det      = out_det_reg;
    assign out_no_value = out_nov_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            imdu_pkg::B_IDLE:
            begin
                if (start && !job_meta.no_value && job_meta.dim > CW'(1))
                    state_next = imdu_pkg::B_MUL;
            end
            imdu_pkg::B_MUL:  state_next = imdu_pkg::B_ACC;
            imdu_pkg::B_ACC:
            begin
                if (col_end && row_end && i_reg == '0)
                    state_next = imdu_pkg::B_COPY;
                else
                    state_next = imdu_pkg::B_MUL;
            end
            imdu_pkg::B_COPY:
            begin
                if (step_reg == n_reg - CW'(1))
                    state_next = imdu_pkg::B_IDLE;
                else
                    state_next = imdu_pkg::B_MUL;
            end
            default: state_next = imdu_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= imdu_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            else if (start && (job_meta.no_value || job_meta.dim <= CW'(1)))
                out_valid_reg <= 1'b1;
            else if (state_reg == imdu_pkg::B_COPY && step_reg == n_reg - CW'(1))
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            imdu_pkg::B_IDLE:
            begin
                if (start)
                begin
                    for (int e = 0; e < N2; e++)
                    begin
                        a_reg[e] <= job_mat[e*DW +: DW];
                        x_reg[e] <= job_mat[e*DW +: DW];
                    end
                    n_reg       <= job_meta.dim;
                    step_reg    <= CW'(1);
                    i_reg       <= job_meta.dim - CW'(1);
                    k_reg       <= job_meta.dim - CW'(1);
                    j_reg       <= '0;
                    acc_reg     <= '0;
                    tr_reg      <= '0;
                    out_nov_reg <= job_meta.no_value;
                    out_det_reg <= job_meta.no_value ? '0 : job_mat[DW-1:0];
                end
            end
            imdu_pkg::B_MUL:
            begin
                p_reg <= opnd * a_el;
            end
            imdu_pkg::B_ACC:
            begin
                if (col_end)
                begin
                    y_reg[idx(i_reg, j_reg)] <= sum;
                    acc_reg <= '0;
                    if (row_end)
                    begin
                        tr_reg <= tr_reg + x_reg[idx(i_reg, i_reg)];
                        j_reg  <= '0;
                        if (i_reg != '0)
                        begin
                            i_reg <= i_reg - CW'(1);
                            k_reg <= i_reg - CW'(1);
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + CW'(1);
                        k_reg <= i_reg;
                    end
                end
                else
                begin
                    k_reg   <= k_reg + CW'(1);
                    acc_reg <= sum;
                end
            end
            imdu_pkg::B_COPY:
            begin
                for (int e = 0; e < N2; e++)
                    x_reg[e] <= y_reg[e];
                tr_reg   <= '0;
                step_reg <= step_reg + CW'(1);
                i_reg    <= n_reg - CW'(1);
                k_reg    <= n_reg - CW'(1);
                j_reg    <= '0;
                out_det_reg <= n_reg[0] ? y_reg[0] : (DW'(0) - y_reg[0]);
            end
            default:
            begin
                p_reg <= p_reg;
            end
        endcase
    end

endmodule

// ===== rtl/integer_matrix_determinant_unit.sv =====
// Top level of the integer matrix determinant unit.
// Depends on imdu_pkg, imdu_front, imdu_queue, imdu_back.
`timescale 1ns / 1ps

// Entries stream in row-major order, one 32-bit item per cycle while the job
// queue is not full, into a loader that hands each finished matrix to a
// two-entry job queue; a determinant engine drains the queue and posts one
// result per matrix (det in tdata, no_value in tuser). The engine runs a single
// multiply-accumulate unit: each product is formed in a multiply state and
// added in an accumulate state, and a copy state closes each iteration step.
// Non-square and 1 x 1 matrices skip the iteration and post their result on pop.
// A config write drops any partly loaded matrix.

module integer_matrix_determinant_unit #(
    parameter int MAX_DIM = imdu_pkg::DEFAULT_MAX_DIM
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [imdu_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,   // [31:0] entry_value
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata,   // [31:0] det_value
    output logic                        m_axis_tuser    // [0] no_value
);

    localparam int N2    = MAX_DIM * MAX_DIM;
    localparam int MAT_W = N2 * imdu_pkg::DATA_W;
    localparam int JOB_W = MAT_W + $bits(imdu_pkg::job_meta_t);

    logic                push, q_full, q_pop, q_valid;
    logic [MAT_W-1:0]    push_mat;
    imdu_pkg::job_meta_t push_meta, pop_meta;
    logic [JOB_W-1:0]    pop_data;

    assign pready   = 1'b1;
    assign pop_meta = pop_data[JOB_W-1:MAT_W];

    imdu_front #(.MAX_DIM(MAX_DIM)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .push      (push),
        .push_mat  (push_mat),
        .push_meta (push_meta),
        .q_full    (q_full)
    );

    imdu_queue #(.WIDTH(JOB_W)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_meta, push_mat}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (pop_data)
    );

    imdu_back #(.MAX_DIM(MAX_DIM)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (q_valid),
        .job_mat      (pop_data[MAT_W-1:0]),
        .job_meta     (pop_meta),
        .job_pop      (q_pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_det      (m_axis_tdata),
        .out_no_value (m_axis_tuser)
    );

    a_ready_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !q_full)
        else $error("input ready while job queue full");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("job popped from empty queue");

    a_no_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("non-square result with nonzero determinant");

    a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> m_axis_tvalid || !$past(pop_meta.no_value))
        else $error("non-square job did not post a result");

endmodule

// ===== tb/imdu_checker.sv =====
// Checker for the integer matrix determinant unit: tracks register writes,
// predicts one determinant per finished matrix and compares result items.
// Depends on imdu_pkg for the address width.
`timescale 1ns / 1ps

module imdu_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [imdu_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,   // [31:0] entry_value
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [31:0]                 m_axis_tdata,   // [31:0] det_value
    input  logic                        m_axis_tuser,   // [0] no_value
    output int                          fail_count,
    output int                          pending
);

    localparam int MAXD = imdu_pkg::DEFAULT_MAX_DIM;

    typedef struct packed {
        logic [31:0] det_value;
        logic        no_value;
    } det_result_t;

    det_result_t                det_queue[$];
    logic [imdu_pkg::CFG_W-1:0] rows_reg;
    logic [imdu_pkg::CFG_W-1:0] cols_reg;
    logic [511:0]               matrix;
    int                         load_pos;

    function automatic int clamp_dim(input logic [imdu_pkg::CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAXD)
            return MAXD;
        return int'(v);
    endfunction

    // cofactor expansion along row 0, wrapping modulo 2^32
    function automatic logic [31:0] det_of_matrix(input logic [511:0] m, input int n);
        logic [511:0] minor;
        logic [31:0]  acc;
        logic [31:0]  term;
        int           k;
        if (n <= 1)
            return m[31:0];
        acc = '0;
        for (int j = 0; j < n; j++)
        begin
            k = 0;
            minor = '0;
            for (int r = 1; r < n; r++)
                for (int c = 0; c < n; c++)
                    if (c != j)
                    begin
                        minor[k*32 +: 32] = m[(r*n + c)*32 +: 32];
                        k++;
                    end
            term = m[j*32 +: 32] * det_of_matrix(minor, n - 1);
            if (j % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        return acc;
    endfunction

    assign pending = det_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        int          nr;
        int          nc;
        det_result_t res;
        det_result_t want;
        if (!rst_n)
        begin
            rows_reg   <= 3'd4;
            cols_reg   <= 3'd4;
            load_pos   = 0;
            matrix     = '0;
            fail_count <= 0;
            det_queue.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == imdu_pkg::CFG_IDX_COL)
                    cols_reg <= pwdata[imdu_pkg::CFG_W-1:0];
                else
                    rows_reg <= pwdata[imdu_pkg::CFG_W-1:0];
                load_pos = 0;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                nr = clamp_dim(rows_reg);
                nc = clamp_dim(cols_reg);
                if (load_pos >= nr * nc)
                    load_pos = 0;
                matrix[load_pos*32 +: 32] = s_axis_tdata;
                load_pos++;
                if (load_pos >= nr * nc)
                begin
                    load_pos = 0;
                    if (nr != nc)
                        res = '{det_value: '0, no_value: 1'b1};
                    else
                        res = '{det_value: det_of_matrix(matrix, nr), no_value: 1'b0};
                    det_queue = {det_queue, res};
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (det_queue.size() == 0)
                begin
                    $error("unexpected result item det_value=%h no_value=%b",
                           m_axis_tdata, m_axis_tuser);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = det_queue.pop_front();
                    if (want.det_value !== m_axis_tdata || want.no_value !== m_axis_tuser)
                        fail_count <= fail_count + 1;
                    if (want.det_value !== m_axis_tdata)
                        $error("det_value expected %h actual %h",
                               want.det_value, m_axis_tdata);
                    if (want.no_value !== m_axis_tuser)
                        $error("no_value expected %b actual %b",
                               want.no_value, m_axis_tuser);
                end
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the integer matrix determinant unit: clock, reset, APB
// register writes, entry stimulus with random idling, and the verdict.
// Depends on imdu_pkg, integer_matrix_determinant_unit and imdu_checker.
`timescale 1ns / 1ps

module tb;

    localparam logic [imdu_pkg::ADDR_W-1:0] ROW_ADDR =
        imdu_pkg::ADDR_W'(4 * imdu_pkg::CFG_IDX_ROW);
    localparam logic [imdu_pkg::ADDR_W-1:0] COL_ADDR =
        imdu_pkg::ADDR_W'(4 * imdu_pkg::CFG_IDX_COL);
    localparam int                WATCHDOG = 20000;
    localparam int                ITEM_GOAL = 1550;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [imdu_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [31:0]                 s_axis_tdata = '0;   // [31:0] entry_value
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [31:0]                 m_axis_tdata;       // [31:0] det_value
    logic                        m_axis_tuser;       // [0] no_value

    int fail_count;
    int pending;
    int tx_idle_pct = 10;
    int rx_idle_pct = 52;
    int sent = 0;
    int stall_cycles = 0;
    int hold_left = 0;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;

    always #2 clk = ~clk;

    integer_matrix_determinant_unit dut (.*);

    imdu_checker u_checker (.*);

    always @(negedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= 1500;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom % 100) >= rx_idle_pct;
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic apb_write(input logic [imdu_pkg::ADDR_W-1:0] addr,
                             input logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_entry(input logic [31:0] v);
        while (($urandom % 100) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= v;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic set_shape(input logic [31:0] r, input logic [31:0] c);
        wait_idle();
        apb_write(ROW_ADDR, r);
        apb_write(COL_ADDR, c);
    endtask

    function automatic logic [31:0] pick_entry();
        case ($urandom % 8)
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0;
            4: return $urandom_range(0, 6) - 3;
            default: return $urandom;
        endcase
    endfunction

    function automatic int dim_of(input logic [31:0] v);
        if (v[2:0] == 0)
            return 1;
        if (v[2:0] > 4)
            return 4;
        return int'(v[2:0]);
    endfunction

    initial
    begin
        logic [31:0] r;
        logic [31:0] c;
        int          n;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset shape 4x4: alternating extreme entries
        for (int i = 0; i < 16; i++)
            send_entry(i % 2 ? 32'h8000_0000 : 32'h7fff_ffff);
        set_shape(1, 1);
        send_entry(32'h8000_0000);
        send_entry(32'hffff_ffff);
        set_shape(0, 7);
        for (int i = 0; i < 4; i++)
            send_entry(pick_entry());
        // partial matrix dropped by a register write
        set_shape(2, 2);
        send_entry(32'h1234_5678);
        send_entry(32'h1);
        set_shape(2, 2);
        for (int i = 0; i < 4; i++)
            send_entry(i == 0 || i == 3 ? 32'h1 : 32'h0);

        while (sent < ITEM_GOAL)
        begin
            if (sent > 2 * ITEM_GOAL / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else if (sent > ITEM_GOAL / 3)
            begin
                tx_idle_pct = 52;
                rx_idle_pct = 10;
            end
            r = $urandom_range(0, 7);
            c = ($urandom % 2) ? r : $urandom_range(0, 7);
            if ($urandom % 4 != 0)
            begin
                r = $urandom_range(0, 3);
                c = ($urandom % 3 == 0) ? $urandom_range(0, 3) : r;
            end
            r[31:3] = 29'($urandom);
            c[31:3] = 29'($urandom);
            set_shape(r, c);
            n = dim_of(r) * dim_of(c);
            if (tx_idle_pct == 0 && !hold_go)
            begin
                hold_go <= 1'b1;
                for (int i = 0; i < 5 * n; i++)
                    send_entry(pick_entry());
            end
            else
            begin
                for (int k = $urandom_range(1, 6); k > 0; k--)
                    for (int i = 0; i < n; i++)
                        send_entry(pick_entry());
                if ($urandom % 6 == 0)
                    for (int i = $urandom_range(1, n); i > 0; i--)
                        send_entry(pick_entry());
            end
        end
        wait_idle();
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/imdu_pkg.sv
rtl/imdu_front.sv
rtl/imdu_queue.sv
rtl/imdu_back.sv
rtl/integer_matrix_determinant_unit.sv
tb/imdu_checker.sv
tb/tb.sv
